### hdl/tilemap_pingpong_autoscroll_core_macros.svh
// ------------------------------------------------------------------------
// tilemap pan core assertion macros
// shared concurrent check wrappers, clocked on clock and gated by reset
// ------------------------------------------------------------------------
`ifndef TILEMAP_PINGPONG_AUTOSCROLL_CORE_MACROS_SVH
`define TILEMAP_PINGPONG_AUTOSCROLL_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition that holds at every edge out of reset
`define TPA_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// condition in one cycle implies another in the next
`define TPA_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define TPA_ASSERT_ALWAYS(lbl, cond, msg)
`define TPA_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

### hdl/tpa_pkg.sv
// ------------------------------------------------------------------------
// tpa_pkg
// types and fixed constants of the tile map auto-pan core
// ------------------------------------------------------------------------
package tpa_pkg;

   // visible window in tiles
   localparam logic [6:0] VIEW_COLS = 7'd20;
   localparam logic [6:0] VIEW_ROWS = 7'd15;

   // speed divider: (SLOW_BASE - excess) >> 2 while excess is below SLOW_LIMIT
   localparam logic [7:0] SLOW_LIMIT = 8'd9;
   localparam logic [3:0] SLOW_BASE  = 4'd12;

   // animation frame offset wraps here
   localparam logic [6:0] ANIM_WRAP = 7'd64;

   // operation codes
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // register indexes
   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   // scroll direction
   typedef enum logic [2:0] {
      DIR_RIGHT = 3'd0,
      DIR_DOWN  = 3'd1,
      DIR_LEFT  = 3'd2,
      DIR_UP    = 3'd3,
      DIR_NONE  = 3'd4
   } dir_type;

   // one result transaction
   typedef struct packed {
      logic [4:0]         pixel_x;
      logic [4:0]         pixel_y;
      logic [6:0]         draw_col;
      logic [6:0]         draw_row;
      logic signed [12:0] global_x;
      logic signed [12:0] global_y;
      logic [5:0]         anim_frame;
      logic               surface_update;
      logic               full_refresh;
      logic [2:0]         direction;
   } result_type;

endpackage

### hdl/tilemap_pingpong_autoscroll_core.sv
// ------------------------------------------------------------------------
// tilemap_pingpong_autoscroll_core
// auto-pan controller for a tile map larger than a 20 by 15 tile window
// ------------------------------------------------------------------------
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  operation, visible
// rsp_      out        rsp_valid/rsp_stall  pixel, draw, global, anim, flags, direction
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// one transaction per cycle while req_stall is low; results are registered in
// a two-slot result queue, fed by a single-pass state update from the state
// registers, so req_stall rises only when both slots wait on rsp_stall
// csr_ready is always high; registers reset to width 20 and height 15
// reset is synchronous and clears the pan state and the queue
// ------------------------------------------------------------------------
module tilemap_pingpong_autoscroll_core
   import tpa_pkg::*;
#(
   parameter int TILE_SIZE = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic               req_visible,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_pixel_x,
   output logic [4:0]         rsp_pixel_y,
   output logic [6:0]         rsp_draw_col,
   output logic [6:0]         rsp_draw_row,
   output logic signed [12:0] rsp_global_x,
   output logic signed [12:0] rsp_global_y,
   output logic [5:0]         rsp_anim_frame,
   output logic               rsp_surface_update,
   output logic               rsp_full_refresh,
   output logic [2:0]         rsp_direction,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [6:0]         csr_data
);

   logic       accept;
   logic       queue_full;
   logic [6:0] map_width_ff, map_height_ff;
   result_type step_result;
   result_type rsp_data;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // map size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 7'd20;
         map_height_ff <= 7'd15;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_width_ff  <= csr_data;
            CSR_MAP_HEIGHT: map_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pan state and update
   tpa_step #(
      .TILE_SIZE (TILE_SIZE)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_operation),
      .visible    (req_visible),
      .map_width  (map_width_ff),
      .map_height (map_height_ff),
      .result     (step_result)
   );

   // result queue
   tpa_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_result),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // result fields
   assign rsp_pixel_x        = rsp_data.pixel_x;
   assign rsp_pixel_y        = rsp_data.pixel_y;
   assign rsp_draw_col       = rsp_data.draw_col;
   assign rsp_draw_row       = rsp_data.draw_row;
   assign rsp_global_x       = rsp_data.global_x;
   assign rsp_global_y       = rsp_data.global_y;
   assign rsp_anim_frame     = rsp_data.anim_frame;
   assign rsp_surface_update = rsp_data.surface_update;
   assign rsp_full_refresh   = rsp_data.full_refresh;
   assign rsp_direction      = rsp_data.direction;

endmodule

### hdl/tpa_step.sv
// ------------------------------------------------------------------------
// tpa_step
// pan state registers and the single-pass update for one transaction
// ------------------------------------------------------------------------
`include "tilemap_pingpong_autoscroll_core_macros.svh"

module tpa_step
   import tpa_pkg::*;
#(
   parameter int TILE_SIZE = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       operation,
   input  logic       visible,
   input  logic [6:0] map_width,
   input  logic [6:0] map_height,
   output result_type result
);

   localparam int OFS_W = $clog2(TILE_SIZE + 1);
   localparam logic [OFS_W-1:0] TILE_OFS  = OFS_W'(TILE_SIZE);
   localparam logic [OFS_W:0]   TILE_CMP  = (OFS_W + 1)'(TILE_SIZE);
   localparam logic [12:0]      TILE_PAN  = 13'(TILE_SIZE);
   localparam logic [6:0]       TILE_ANIM = 7'(TILE_SIZE);

   logic [3:0]       anim_timer_ff, anim_timer_in;
   logic [5:0]       anim_frame_ff, anim_frame_in;
   logic [2:0]       speed_timer_ff, speed_timer_in;
   dir_type          move_dir_ff, move_dir_in;
   logic [OFS_W-1:0] offset_x_ff, offset_x_in;
   logic [OFS_W-1:0] offset_y_ff, offset_y_in;
   logic [6:0]       tile_col_ff, tile_col_in;
   logic [6:0]       tile_row_ff, tile_row_in;
   logic [12:0]      pan_x_ff, pan_x_in;
   logic [12:0]      pan_y_ff, pan_y_in;
   logic             upd, full;

   logic [6:0] cols, rows;
   logic [7:0] total;
   logic [1:0] divider;
   logic [6:0] anim_sum;
   logic [OFS_W:0] ofs_inc;

   // excess beyond the window and the move divider
   always_comb begin
      cols    = (map_width > VIEW_COLS) ? map_width - VIEW_COLS : 7'd0;
      rows    = (map_height > VIEW_ROWS) ? map_height - VIEW_ROWS : 7'd0;
      total   = {1'b0, cols} + {1'b0, rows};
      divider = (total < SLOW_LIMIT) ? 2'((SLOW_BASE - total[3:0]) >> 2) : 2'd0;
   end

   // next state for one transaction
   always_comb begin
      anim_timer_in  = anim_timer_ff;
      anim_frame_in  = anim_frame_ff;
      speed_timer_in = speed_timer_ff;
      move_dir_in    = move_dir_ff;
      offset_x_in    = offset_x_ff;
      offset_y_in    = offset_y_ff;
      tile_col_in    = tile_col_ff;
      tile_row_in    = tile_row_ff;
      pan_x_in       = pan_x_ff;
      pan_y_in       = pan_y_ff;
      upd            = 1'b0;
      full           = 1'b0;
      anim_sum       = {1'b0, anim_frame_ff} + TILE_ANIM;
      ofs_inc        = '0;

      if (operation == OP_RESTART) begin
         anim_timer_in  = '0;
         anim_frame_in  = '0;
         speed_timer_in = '0;
         offset_x_in    = '0;
         offset_y_in    = '0;
         tile_col_in    = '0;
         tile_row_in    = '0;
         pan_x_in       = '0;
         pan_y_in       = '0;
         move_dir_in    = (cols != 7'd0) ? DIR_RIGHT :
                          ((rows != 7'd0) ? DIR_DOWN : DIR_NONE);
         upd            = 1'b1;
         full           = 1'b1;
      end else if (visible) begin
         // tile animation
         anim_timer_in = anim_timer_ff + 4'd1;
         if (anim_timer_in == 4'd0) begin
            anim_frame_in = (anim_sum >= ANIM_WRAP) ? 6'd0 : anim_sum[5:0];
            upd           = 1'b1;
         end
         // scroll step once per divided tick
         speed_timer_in = speed_timer_ff + 3'd1;
         if (speed_timer_in > {1'b0, divider}) begin
            speed_timer_in = '0;
            unique case (move_dir_ff)
               DIR_RIGHT: begin
                  pan_x_in = pan_x_ff - 13'd1;
                  ofs_inc  = {1'b0, offset_x_ff} + (OFS_W + 1)'(1);
                  if (ofs_inc >= TILE_CMP) begin
                     offset_x_in = '0;
                     upd         = 1'b1;
                     full        = 1'b1;
                     tile_col_in = tile_col_ff + 7'd1;
                     if (tile_col_in >= cols) begin
                        if (rows != 7'd0) begin
                           move_dir_in = DIR_DOWN;
                           offset_y_in = '0;
                        end else begin
                           move_dir_in = DIR_LEFT;
                           offset_x_in = TILE_OFS;
                           tile_col_in = tile_col_in - 7'd1;
                           pan_x_in    = pan_x_in + TILE_PAN;
                        end
                     end
                  end else begin
                     offset_x_in = ofs_inc[OFS_W-1:0];
                  end
               end
               DIR_DOWN: begin
                  pan_y_in = pan_y_ff - 13'd1;
                  ofs_inc  = {1'b0, offset_y_ff} + (OFS_W + 1)'(1);
                  if (ofs_inc >= TILE_CMP) begin
                     offset_y_in = '0;
                     upd         = 1'b1;
                     full        = 1'b1;
                     tile_row_in = tile_row_ff + 7'd1;
                     if (tile_row_in >= rows) begin
                        if (cols != 7'd0) begin
                           move_dir_in = DIR_LEFT;
                           offset_x_in = TILE_OFS;
                           tile_col_in = tile_col_ff - 7'd1;
                           pan_x_in    = pan_x_ff + TILE_PAN;
                        end else begin
                           move_dir_in = DIR_UP;
                           offset_y_in = TILE_OFS;
                           tile_row_in = tile_row_in - 7'd1;
                           pan_y_in    = pan_y_in + TILE_PAN;
                        end
                     end
                  end else begin
                     offset_y_in = ofs_inc[OFS_W-1:0];
                  end
               end
               DIR_LEFT: begin
                  pan_x_in = pan_x_ff + 13'd1;
                  if (offset_x_ff != '0) offset_x_in = offset_x_ff - OFS_W'(1);
                  if (offset_x_in == '0) begin
                     upd  = 1'b1;
                     full = 1'b1;
                     if (tile_col_ff == 7'd0) begin
                        pan_x_in = pan_x_in - TILE_PAN;
                        if (rows != 7'd0) begin
                           move_dir_in = DIR_UP;
                           offset_y_in = TILE_OFS;
                           tile_row_in = tile_row_ff - 7'd1;
                           pan_y_in    = pan_y_ff + TILE_PAN;
                        end else begin
                           move_dir_in = DIR_RIGHT;
                           offset_x_in = '0;
                        end
                     end else begin
                        tile_col_in = tile_col_ff - 7'd1;
                        offset_x_in = TILE_OFS;
                     end
                  end
               end
               DIR_UP: begin
                  pan_y_in = pan_y_ff + 13'd1;
                  if (offset_y_ff != '0) offset_y_in = offset_y_ff - OFS_W'(1);
                  if (offset_y_in == '0) begin
                     upd  = 1'b1;
                     full = 1'b1;
                     if (tile_row_ff == 7'd0) begin
                        pan_y_in = pan_y_in - TILE_PAN;
                        if (cols != 7'd0) begin
                           move_dir_in = DIR_RIGHT;
                           offset_x_in = '0;
                        end else begin
                           move_dir_in = DIR_DOWN;
                           offset_y_in = '0;
                        end
                     end else begin
                        tile_row_in = tile_row_ff - 7'd1;
                        offset_y_in = TILE_OFS;
                     end
                  end
               end
               default: begin
                  // no movement
               end
            endcase
         end
      end
   end

   // result from the updated state
   always_comb begin
      result.pixel_x        = 5'(offset_x_in);
      result.pixel_y        = 5'(offset_y_in);
      result.draw_col       = tile_col_in;
      result.draw_row       = tile_row_in;
      result.global_x       = signed'(pan_x_in);
      result.global_y       = signed'(pan_y_in);
      result.anim_frame     = anim_frame_in;
      result.surface_update = upd;
      result.full_refresh   = full;
      result.direction      = move_dir_in;
   end

   // state registers, updated on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         anim_timer_ff  <= '0;
         anim_frame_ff  <= '0;
         speed_timer_ff <= '0;
         move_dir_ff    <= DIR_NONE;
         offset_x_ff    <= '0;
         offset_y_ff    <= '0;
         tile_col_ff    <= '0;
         tile_row_ff    <= '0;
         pan_x_ff       <= '0;
         pan_y_ff       <= '0;
      end else if (accept) begin
         anim_timer_ff  <= anim_timer_in;
         anim_frame_ff  <= anim_frame_in;
         speed_timer_ff <= speed_timer_in;
         move_dir_ff    <= move_dir_in;
         offset_x_ff    <= offset_x_in;
         offset_y_ff    <= offset_y_in;
         tile_col_ff    <= tile_col_in;
         tile_row_ff    <= tile_row_in;
         pan_x_ff       <= pan_x_in;
         pan_y_ff       <= pan_y_in;
      end
   end

   // checks
   `TPA_ASSERT_NEXT(a_restart_clears, accept && operation == OP_RESTART,
      speed_timer_ff == 3'd0 && pan_x_ff == 13'd0 && pan_y_ff == 13'd0 && anim_timer_ff == 4'd0,
      "restart left pan state non-zero")
   `TPA_ASSERT_NEXT(a_hidden_holds, accept && operation == OP_TICK && !visible,
      $stable(pan_x_ff) && $stable(pan_y_ff) && $stable(anim_timer_ff) && $stable(speed_timer_ff),
      "hidden tick changed pan state")
   `TPA_ASSERT_ALWAYS(a_offset_bound, offset_x_ff <= TILE_OFS && offset_y_ff <= TILE_OFS,
      "pixel offset beyond tile size")

endmodule

### hdl/tpa_rsp_queue.sv
// ------------------------------------------------------------------------
// tpa_rsp_queue
// two-slot result queue between the update logic and the result channel
// ------------------------------------------------------------------------
`include "tilemap_pingpong_autoscroll_core_macros.svh"

module tpa_rsp_queue
   import tpa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   result_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_data  = slot_ff[rd_ptr_ff];

   // slot storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   // pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   // checks
   `TPA_ASSERT_ALWAYS(a_no_overflow, !push || count_ff != 2'd2, "push into full queue")
   `TPA_ASSERT_NEXT(a_fill_count, push && !pop, count_ff == $past(count_ff) + 2'd1,
      "occupancy did not rise on push")
   `TPA_ASSERT_NEXT(a_drain_count, pop && !push, count_ff == $past(count_ff) - 2'd1,
      "occupancy did not fall on pop")

endmodule

### tb/tpa_pan_checker.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tpa_pan_checker
// watches the request, result and register channels of the auto-pan core,
// keeps its own copy of the pan state, predicts one result per accepted
// request and compares every accepted result field by field in order
// ------------------------------------------------------------------------
module tpa_pan_checker
   import tpa_pkg::*;
#(
   parameter int TILE_PX = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_operation,
   input  logic               req_visible,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [4:0]         rsp_pixel_x,
   input  logic [4:0]         rsp_pixel_y,
   input  logic [6:0]         rsp_draw_col,
   input  logic [6:0]         rsp_draw_row,
   input  logic signed [12:0] rsp_global_x,
   input  logic signed [12:0] rsp_global_y,
   input  logic [5:0]         rsp_anim_frame,
   input  logic               rsp_surface_update,
   input  logic               rsp_full_refresh,
   input  logic [2:0]         rsp_direction,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_index,
   input  logic [6:0]         csr_data,
   output int                 mismatch_count,
   output int                 outstanding
);

   // map size registers
   logic [6:0]  map_w;
   logic [6:0]  map_h;

   // predicted pan state
   logic [3:0]  anim_tick;
   logic [5:0]  frame_ofs;
   logic [2:0]  step_count;
   dir_type     heading;
   logic [4:0]  px;
   logic [4:0]  py;
   logic [6:0]  col;
   logic [6:0]  row;
   logic [12:0] gx;
   logic [12:0] gy;

   // results still owed by the core, oldest first
   result_type  pan_predictions[$];

   function automatic void clear_pan();
      anim_tick  = '0;
      frame_ofs  = '0;
      step_count = '0;
      px         = '0;
      py         = '0;
      col        = '0;
      row        = '0;
      gx         = '0;
      gy         = '0;
   endfunction

   // turn to scroll left: step back one column and start at a full tile
   function automatic void start_left();
      heading = DIR_LEFT;
      px      = 5'(TILE_PX);
      col     = col - 7'd1;
      gx      = gx + 13'(TILE_PX);
   endfunction

   function automatic void start_up();
      heading = DIR_UP;
      py      = 5'(TILE_PX);
      row     = row - 7'd1;
      gy      = gy + 13'(TILE_PX);
   endfunction

   function automatic result_type predict_pan_step(input logic op, input logic vis);
      logic [6:0] spare_cols;
      logic [6:0] spare_rows;
      logic [7:0] spare_sum;
      logic [3:0] slow_base;
      logic [1:0] slow;
      logic       redraw;
      logic       full;
      result_type res;

      // excess over the window and the speed divider derived from it
      spare_cols = (map_w > VIEW_COLS) ? map_w - VIEW_COLS : 7'd0;
      spare_rows = (map_h > VIEW_ROWS) ? map_h - VIEW_ROWS : 7'd0;
      spare_sum  = {1'b0, spare_cols} + {1'b0, spare_rows};
      if (spare_sum < SLOW_LIMIT) begin
         slow_base = SLOW_BASE - spare_sum[3:0];
         slow      = slow_base[3:2];
      end else begin
         slow = 2'd0;
      end
      redraw = 1'b0;
      full   = 1'b0;

      if (op == OP_RESTART) begin
         clear_pan();
         if (spare_cols != 0) begin
            heading = DIR_RIGHT;
         end else if (spare_rows != 0) begin
            heading = DIR_DOWN;
         end else begin
            heading = DIR_NONE;
         end
         redraw = 1'b1;
         full   = 1'b1;
      end else if (vis) begin
         // tile animation
         anim_tick = anim_tick + 4'd1;
         if (anim_tick == 0) begin
            if (frame_ofs + TILE_PX >= ANIM_WRAP) begin
               frame_ofs = '0;
            end else begin
               frame_ofs = frame_ofs + 6'(TILE_PX);
            end
            redraw = 1'b1;
         end
         // one pixel of scroll per divided tick
         step_count = step_count + 3'd1;
         if (step_count > slow) begin
            step_count = '0;
            case (heading)
               DIR_RIGHT: begin
                  gx = gx - 13'd1;
                  px = px + 5'd1;
                  if (px >= TILE_PX) begin
                     px     = '0;
                     redraw = 1'b1;
                     full   = 1'b1;
                     col    = col + 7'd1;
                     if (col >= spare_cols) begin
                        if (spare_rows != 0) begin
                           heading = DIR_DOWN;
                           py      = '0;
                        end else begin
                           start_left();
                        end
                     end
                  end
               end
               DIR_DOWN: begin
                  gy = gy - 13'd1;
                  py = py + 5'd1;
                  if (py >= TILE_PX) begin
                     py     = '0;
                     redraw = 1'b1;
                     full   = 1'b1;
                     row    = row + 7'd1;
                     if (row >= spare_rows) begin
                        if (spare_cols != 0) begin
                           start_left();
                        end else begin
                           start_up();
                        end
                     end
                  end
               end
               DIR_LEFT: begin
                  gx = gx + 13'd1;
                  if (px > 0) px = px - 5'd1;
                  if (px == 0) begin
                     redraw = 1'b1;
                     full   = 1'b1;
                     if (col == 0) begin
                        // at the left edge: undo the tile pre-offset and turn
                        gx = gx - 13'(TILE_PX);
                        if (spare_rows != 0) begin
                           start_up();
                        end else begin
                           heading = DIR_RIGHT;
                           px      = '0;
                        end
                     end else begin
                        col = col - 7'd1;
                        px  = 5'(TILE_PX);
                     end
                  end
               end
               DIR_UP: begin
                  gy = gy + 13'd1;
                  if (py > 0) py = py - 5'd1;
                  if (py == 0) begin
                     redraw = 1'b1;
                     full   = 1'b1;
                     if (row == 0) begin
                        gy = gy - 13'(TILE_PX);
                        if (spare_cols != 0) begin
                           heading = DIR_RIGHT;
                           px      = '0;
                        end else begin
                           heading = DIR_DOWN;
                           py      = '0;
                        end
                     end else begin
                        row = row - 7'd1;
                        py  = 5'(TILE_PX);
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      res.pixel_x        = px;
      res.pixel_y        = py;
      res.draw_col       = col;
      res.draw_row       = row;
      res.global_x       = gx;
      res.global_y       = gy;
      res.anim_frame     = frame_ofs;
      res.surface_update = redraw;
      res.full_refresh   = full;
      res.direction      = heading;
      return res;
   endfunction

   task automatic compare_field(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   // channel monitor: registers, results, then new requests
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         map_w          = VIEW_COLS;
         map_h          = VIEW_ROWS;
         heading        = DIR_NONE;
         mismatch_count = 0;
         clear_pan();
         pan_predictions.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAP_WIDTH:  map_w = csr_data;
               CSR_MAP_HEIGHT: map_h = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pan_predictions.size() == 0) begin
               $error("result transaction with no request outstanding");
               mismatch_count++;
            end else begin
               want = pan_predictions.pop_front();
               compare_field("pixel_x", 32'(want.pixel_x), 32'(rsp_pixel_x));
               compare_field("pixel_y", 32'(want.pixel_y), 32'(rsp_pixel_y));
               compare_field("draw_col", 32'(want.draw_col), 32'(rsp_draw_col));
               compare_field("draw_row", 32'(want.draw_row), 32'(rsp_draw_row));
               compare_field("global_x", 32'(want.global_x), 32'(rsp_global_x));
               compare_field("global_y", 32'(want.global_y), 32'(rsp_global_y));
               compare_field("anim_frame", 32'(want.anim_frame), 32'(rsp_anim_frame));
               compare_field("surface_update", 32'(want.surface_update),
                             32'(rsp_surface_update));
               compare_field("full_refresh", 32'(want.full_refresh),
                             32'(rsp_full_refresh));
               compare_field("direction", 32'(want.direction), 32'(rsp_direction));
            end
         end
         if (req_valid && !req_stall) begin
            pan_predictions.push_back(predict_pan_step(req_operation, req_visible));
         end
      end
      outstanding <= pan_predictions.size();
   end

endmodule

### tb/tb_tilemap_pingpong_autoscroll_core.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_tilemap_pingpong_autoscroll_core
// drives ticks and restarts into the auto-pan core over a series of map
// sizes, some changed mid-scroll, with random sender gaps and result
// stalls; the checker beside the core predicts and compares every result
// ------------------------------------------------------------------------
module tb_tilemap_pingpong_autoscroll_core;
   import tpa_pkg::*;

   localparam int RUN_LIMIT = 200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = OP_TICK;
   logic               req_visible = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [4:0]         rsp_pixel_x;
   logic [4:0]         rsp_pixel_y;
   logic [6:0]         rsp_draw_col;
   logic [6:0]         rsp_draw_row;
   logic signed [12:0] rsp_global_x;
   logic signed [12:0] rsp_global_y;
   logic [5:0]         rsp_anim_frame;
   logic               rsp_surface_update;
   logic               rsp_full_refresh;
   logic [2:0]         rsp_direction;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = CSR_MAP_WIDTH;
   logic [6:0]         csr_data = 7'd0;

   int mismatch_count;
   int outstanding;
   int cycle_count = 0;
   int gap_pct = 0;
   int stall_pct = 0;

   always #5 clock = ~clock;

   tilemap_pingpong_autoscroll_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_visible        (req_visible),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_y        (rsp_pixel_y),
      .rsp_draw_col       (rsp_draw_col),
      .rsp_draw_row       (rsp_draw_row),
      .rsp_global_x       (rsp_global_x),
      .rsp_global_y       (rsp_global_y),
      .rsp_anim_frame     (rsp_anim_frame),
      .rsp_surface_update (rsp_surface_update),
      .rsp_full_refresh   (rsp_full_refresh),
      .rsp_direction      (rsp_direction),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   tpa_pan_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_visible        (req_visible),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_y        (rsp_pixel_y),
      .rsp_draw_col       (rsp_draw_col),
      .rsp_draw_row       (rsp_draw_row),
      .rsp_global_x       (rsp_global_x),
      .rsp_global_y       (rsp_global_y),
      .rsp_anim_frame     (rsp_anim_frame),
      .rsp_surface_update (rsp_surface_update),
      .rsp_full_refresh   (rsp_full_refresh),
      .rsp_direction      (rsp_direction),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding)
   );

   // result back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one request transaction, with random gaps ahead of it
   task automatic send_item(input logic op, input logic vis);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid     <= 1'b0;
         req_operation <= 1'($urandom_range(0, 1));
         req_visible   <= 1'($urandom_range(0, 1));
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_visible   <= vis;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and wait for every owed result
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // write both map size registers back to back
   task automatic write_map(input logic [6:0] width, input logic [6:0] height);
      csr_valid <= 1'b1;
      csr_index <= CSR_MAP_WIDTH;
      csr_data  <= width;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_MAP_HEIGHT;
      csr_data  <= height;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly visible ticks, some hidden ones, occasional restarts
   task automatic random_ticks(input int count, input int restart_pct);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < restart_pct) begin
            send_item(OP_RESTART, 1'($urandom_range(0, 1)));
         end else if (pick < restart_pct + 12) begin
            send_item(OP_TICK, 1'b0);
         end else begin
            send_item(OP_TICK, 1'b1);
         end
      end
   endtask

   task automatic run_phase(input logic [6:0] width, input logic [6:0] height,
                            input bit restart, input int count, input int gaps,
                            input int stalls, input int restart_pct);
      drain();
      write_map(width, height);
      gap_pct   = gaps;
      stall_pct = stalls;
      if (restart) send_item(OP_RESTART, 1'($urandom_range(0, 1)));
      random_ticks(count, restart_pct);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default map fits the window: nothing moves, restart gives no direction
      send_item(OP_TICK, 1'b0);
      send_item(OP_TICK, 1'b1);
      send_item(OP_RESTART, 1'b0);
      send_item(OP_TICK, 1'b1);

      // widest map scrolls right on every visible tick
      drain();
      write_map(7'd127, 7'd1);
      send_item(OP_RESTART, 1'b1);
      repeat (3) send_item(OP_TICK, 1'b1);
      send_item(OP_TICK, 1'b0);

      // tallest map scrolls down first
      drain();
      write_map(7'd1, 7'd127);
      send_item(OP_RESTART, 1'b0);
      repeat (3) send_item(OP_TICK, 1'b1);
      send_item(OP_RESTART, 1'b1);
      send_item(OP_TICK, 1'b1);

      // one spare column, then a spare row appears while scrolling left
      run_phase(7'd21, 7'd15, 1'b1, 70, 0, 0, 0);
      run_phase(7'd21, 7'd16, 1'b0, 60, 71, 0, 0);
      // one spare row, then a spare column appears while scrolling down
      run_phase(7'd20, 7'd16, 1'b1, 30, 0, 71, 0);
      run_phase(7'd21, 7'd16, 1'b0, 50, 6, 6, 0);
      // ping-pong scrolling at assorted speeds
      run_phase(7'd22, 7'd17, 1'b1, 110, 0, 0, 3);
      run_phase(7'd29, 7'd15, 1'b1, 60, 0, 71, 3);
      // excess removed mid-scroll
      run_phase(7'd1, 7'd1, 1'b0, 30, 71, 0, 3);
      run_phase(7'd127, 7'd127, 1'b1, 40, 6, 6, 3);
      run_phase(7'd20, 7'd15, 1'b0, 30, 0, 0, 5);

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
